### src/ibs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared types and constants for the I2C register burst sequencer.
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int unsigned COUNT_WIDTH = 8;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [2:0] {
    PH_DONE        = 3'd0,
    PH_START_WRITE = 3'd1,
    PH_SEND_REG    = 3'd2,
    PH_START_READ  = 3'd3,
    PH_WRITE_DATA  = 3'd4,
    PH_READ_DATA   = 3'd5,
    PH_SEND_STOP   = 3'd6
  } phase_t;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  slave_addr;
    logic [7:0]  reg_addr;
    logic [7:0]  byte_count;
    logic        read_mode;
    logic [31:0] done_tag;
    logic        ack_flag;
    logic        rx_flag;
    logic        stop_flag;
    logic [7:0]  rx_data;
    logic [7:0]  tx_data;
  } item_t;

  typedef struct packed {
    logic        send_start;
    logic        issue_stop;
    logic        send_ack;
    logic        send_nack;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_used;
    logic        rx_valid;
    logic [7:0]  rx_out;
    logic        finished;
    logic [31:0] finished_tag;
    logic        proto_error;
  } result_t;

  typedef struct packed {
    phase_t phase;
    logic   busy;
  } status_t;

endpackage
`default_nettype wire

### src/ibs_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibs_in_if / ibs_out_if
// Valid/ready channels for requests and results of the burst sequencer.
// ----------------------------------------------------------------------------
interface ibs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [6:0]  slave_addr;
  logic [7:0]  reg_addr;
  logic [7:0]  byte_count;
  logic        read_mode;
  logic [31:0] done_tag;
  logic        ack_flag;
  logic        rx_flag;
  logic        stop_flag;
  logic [7:0]  rx_data;
  logic [7:0]  tx_data;

  modport source (
    output valid, cmd, slave_addr, reg_addr, byte_count, read_mode, done_tag,
           ack_flag, rx_flag, stop_flag, rx_data, tx_data,
    input  ready
  );
  modport sink (
    input  valid, cmd, slave_addr, reg_addr, byte_count, read_mode, done_tag,
           ack_flag, rx_flag, stop_flag, rx_data, tx_data,
    output ready
  );
endinterface

interface ibs_out_if;
  logic        valid;
  logic        ready;
  logic        send_start;
  logic        issue_stop;
  logic        send_ack;
  logic        send_nack;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        tx_used;
  logic        rx_valid;
  logic [7:0]  rx_out;
  logic        finished;
  logic [31:0] finished_tag;
  logic        proto_error;

  modport source (
    output valid, send_start, issue_stop, send_ack, send_nack, tx_valid, tx_byte,
           tx_used, rx_valid, rx_out, finished, finished_tag, proto_error,
    input  ready
  );
  modport sink (
    input  valid, send_start, issue_stop, send_ack, send_nack, tx_valid, tx_byte,
           tx_used, rx_valid, rx_out, finished, finished_tag, proto_error,
    output ready
  );
endinterface
`default_nettype wire

### src/ibs_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibs_in_stage
// Input register: holds one request until the sequencer step takes it.
// ----------------------------------------------------------------------------
module ibs_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire ibs_pkg::item_t in_item,
  input  wire logic           adv,
  output logic                in_ready,
  output logic                stage_valid,
  output ibs_pkg::item_t      stage_item
);

  logic           valid_r;
  logic           valid_nxt;
  ibs_pkg::item_t item_r;
  logic           take;

  assign in_ready = !valid_r || adv;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule
`default_nettype wire

### src/ibs_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibs_seq
// Transfer state and one-step phase logic: begin, then ack, rx and stop flags.
// ----------------------------------------------------------------------------
module ibs_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire ibs_pkg::item_t item,
  output ibs_pkg::result_t    res,
  output ibs_pkg::status_t    status
);

  ibs_pkg::phase_t phase_r,       phase_nxt;
  ibs_pkg::count_t bytes_done_r,  bytes_done_nxt;
  ibs_pkg::count_t bytes_total_r, bytes_total_nxt;
  logic [6:0]      target_addr_r, target_addr_nxt;
  logic [7:0]      target_reg_r,  target_reg_nxt;
  logic            is_read_r,     is_read_nxt;
  logic [31:0]     saved_tag_r,   saved_tag_nxt;
  logic            busy;

  assign busy = (phase_r != ibs_pkg::PH_DONE);

  always_comb begin
    phase_nxt       = phase_r;
    bytes_done_nxt  = bytes_done_r;
    bytes_total_nxt = bytes_total_r;
    target_addr_nxt = target_addr_r;
    target_reg_nxt  = target_reg_r;
    is_read_nxt     = is_read_r;
    saved_tag_nxt   = saved_tag_r;
    res             = '0;

    if (item.cmd == ibs_pkg::CMD_BEGIN) begin
      if (busy) begin
        res.proto_error = 1'b1;
      end else begin
        target_addr_nxt = item.slave_addr;
        target_reg_nxt  = item.reg_addr;
        bytes_total_nxt = ibs_pkg::count_t'(item.byte_count);
        is_read_nxt     = item.read_mode;
        saved_tag_nxt   = item.done_tag;
        bytes_done_nxt  = '0;
        phase_nxt       = ibs_pkg::PH_START_WRITE;
        res.send_start  = 1'b1;
        res.tx_valid    = 1'b1;
        res.tx_byte     = {item.slave_addr, 1'b0};
      end
    end else begin
      // flags are taken in order ack, rx, stop against the updated phase
      if (item.ack_flag) begin
        case (phase_nxt)
          ibs_pkg::PH_START_WRITE: begin
            phase_nxt    = ibs_pkg::PH_SEND_REG;
            res.tx_valid = 1'b1;
            res.tx_byte  = target_reg_r;
          end
          ibs_pkg::PH_SEND_REG: begin
            if (is_read_r) begin
              phase_nxt      = ibs_pkg::PH_START_READ;
              res.send_start = 1'b1;
              res.tx_valid   = 1'b1;
              res.tx_byte    = {target_addr_r, 1'b1};
            end else begin
              phase_nxt      = ibs_pkg::PH_WRITE_DATA;
              res.tx_valid   = 1'b1;
              res.tx_byte    = item.tx_data;
              res.tx_used    = 1'b1;
              bytes_done_nxt = bytes_done_nxt + ibs_pkg::count_t'(1);
            end
          end
          ibs_pkg::PH_START_READ: begin
            phase_nxt = ibs_pkg::PH_READ_DATA;
          end
          ibs_pkg::PH_WRITE_DATA: begin
            if (bytes_done_nxt == bytes_total_r) begin
              phase_nxt      = ibs_pkg::PH_SEND_STOP;
              res.issue_stop = 1'b1;
            end else begin
              res.tx_valid   = 1'b1;
              res.tx_byte    = item.tx_data;
              res.tx_used    = 1'b1;
              bytes_done_nxt = bytes_done_nxt + ibs_pkg::count_t'(1);
            end
          end
          ibs_pkg::PH_READ_DATA: begin
          end
          default: begin
            res.proto_error = 1'b1;
          end
        endcase
      end

      if (item.rx_flag) begin
        if (phase_nxt != ibs_pkg::PH_READ_DATA) begin
          res.proto_error = 1'b1;
        end else begin
          res.rx_valid   = 1'b1;
          res.rx_out     = item.rx_data;
          bytes_done_nxt = bytes_done_nxt + ibs_pkg::count_t'(1);
          if (bytes_done_nxt == bytes_total_r) begin
            phase_nxt      = ibs_pkg::PH_SEND_STOP;
            res.send_nack  = 1'b1;
            res.issue_stop = 1'b1;
          end else begin
            res.send_ack = 1'b1;
          end
        end
      end

      if (item.stop_flag) begin
        if (phase_nxt != ibs_pkg::PH_SEND_STOP) begin
          res.proto_error = 1'b1;
        end else begin
          phase_nxt        = ibs_pkg::PH_DONE;
          res.finished     = 1'b1;
          res.finished_tag = saved_tag_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= ibs_pkg::PH_DONE;
      bytes_done_r  <= '0;
      bytes_total_r <= '0;
      target_addr_r <= '0;
      target_reg_r  <= '0;
      is_read_r     <= 1'b0;
      saved_tag_r   <= '0;
    end else if (en) begin
      phase_r       <= phase_nxt;
      bytes_done_r  <= bytes_done_nxt;
      bytes_total_r <= bytes_total_nxt;
      target_addr_r <= target_addr_nxt;
      target_reg_r  <= target_reg_nxt;
      is_read_r     <= is_read_nxt;
      saved_tag_r   <= saved_tag_nxt;
    end
  end

  assign status.phase = phase_r;
  assign status.busy  = busy;

endmodule
`default_nettype wire

### src/ibs_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibs_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module ibs_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire ibs_pkg::result_t res_in,
  input  wire logic             out_ready,
  output logic                  adv,
  output logic                  out_valid,
  output ibs_pkg::result_t      out_res
);

  logic             valid_r;
  logic             valid_nxt;
  ibs_pkg::result_t res_r;

  // slot is free when empty or being drained this cycle
  assign adv = !valid_r || out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

### src/i2c_register_burst_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_burst_sequencer
// A request passes the input reg, then the result reg, before its result is
// valid; a result held by the consumer keeps it waiting in the input reg.
// Throughput: one request per cycle; a result held by the consumer stalls input.
// Every request gives exactly one result.
// Reset (rst_n low, synchronous): both stages empty, phase back to done, idle.
// ----------------------------------------------------------------------------
module i2c_register_burst_sequencer (
  input  wire logic clk,
  input  wire logic rst_n,
  ibs_in_if.sink    in_ch,
  ibs_out_if.source out_ch
);

  ibs_pkg::item_t   in_item;
  ibs_pkg::item_t   stage_item;
  ibs_pkg::result_t step_res;
  ibs_pkg::result_t out_res;
  ibs_pkg::status_t status;
  logic             in_ready;
  logic             stage_valid;
  logic             adv;
  logic             step_en;
  logic             out_valid;

  assign in_item.cmd        = in_ch.cmd;
  assign in_item.slave_addr = in_ch.slave_addr;
  assign in_item.reg_addr   = in_ch.reg_addr;
  assign in_item.byte_count = in_ch.byte_count;
  assign in_item.read_mode  = in_ch.read_mode;
  assign in_item.done_tag   = in_ch.done_tag;
  assign in_item.ack_flag   = in_ch.ack_flag;
  assign in_item.rx_flag    = in_ch.rx_flag;
  assign in_item.stop_flag  = in_ch.stop_flag;
  assign in_item.rx_data    = in_ch.rx_data;
  assign in_item.tx_data    = in_ch.tx_data;
  assign in_ch.ready        = in_ready;

  ibs_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_item     (in_item),
    .adv         (adv),
    .in_ready    (in_ready),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  assign step_en = stage_valid && adv;

  ibs_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (step_en),
    .item   (stage_item),
    .res    (step_res),
    .status (status)
  );

  ibs_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .res_in    (step_res),
    .out_ready (out_ch.ready),
    .adv       (adv),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.send_start   = out_res.send_start;
  assign out_ch.issue_stop   = out_res.issue_stop;
  assign out_ch.send_ack     = out_res.send_ack;
  assign out_ch.send_nack    = out_res.send_nack;
  assign out_ch.tx_valid     = out_res.tx_valid;
  assign out_ch.tx_byte      = out_res.tx_byte;
  assign out_ch.tx_used      = out_res.tx_used;
  assign out_ch.rx_valid     = out_res.rx_valid;
  assign out_ch.rx_out       = out_res.rx_out;
  assign out_ch.finished     = out_res.finished;
  assign out_ch.finished_tag = out_res.finished_tag;
  assign out_ch.proto_error  = out_res.proto_error;

  // a completion that is still waiting leaves the sequencer idle
  a_finished_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.finished |-> !status.busy && status.phase == ibs_pkg::PH_DONE)
    else $error("finished result while sequencer busy");

  // a consumed data byte is always driven on the bus, never with a start
  a_tx_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.tx_used |-> out_res.tx_valid && !out_res.send_start)
    else $error("tx_used without a plain data byte");

  // ack and nack are exclusive and only come with a received byte
  a_ack_nack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.send_ack || out_res.send_nack) |->
      out_res.rx_valid && !(out_res.send_ack && out_res.send_nack))
    else $error("bad ack/nack on result");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !stage_valid && !out_valid)
    else $error("stages not empty after reset");

endmodule
`default_nettype wire
